[hdl/tfls_pkg.sv]
// Shared types, constants and register codes of the tape feeder lane sequencer.
`timescale 1ns / 1ps

package tfls_pkg;

    localparam int EDGE_CNT_W_DEF = 10;
    localparam int LEN_W          = 8;
    localparam int PPU_W          = 4;
    localparam int TGT_W          = PPU_W + LEN_W;
    localparam int FILT_W         = 6;
    localparam int TIMER_W        = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;

    typedef enum logic [2:0] {
        PH_INIT   = 3'd0,
        PH_IDLE   = 3'd1,
        PH_FWD    = 3'd2,
        PH_REV    = 3'd3,
        PH_BRAKE  = 3'd4,
        PH_SETTLE = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        MOTOR_COAST   = 2'd0,
        MOTOR_FORWARD = 2'd1,
        MOTOR_REVERSE = 2'd2,
        MOTOR_BRAKE   = 2'd3
    } t_motor;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSES_PER_UNIT    = 3'd0,
        CFG_RETURN_EDGES       = 3'd1,
        CFG_FILTER_SAMPLES     = 3'd2,
        CFG_BRAKE_TICKS        = 3'd3,
        CFG_SETTLE_TICKS       = 3'd4,
        CFG_INIT_REVERSE_TICKS = 3'd5
    } t_cfg_idx;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_FEED = 1'b1;

    typedef struct packed {
        logic [PPU_W-1:0]   pulses_per_unit;
        logic [3:0]         return_edges;
        logic [FILT_W-1:0]  filter_samples;
        logic [TIMER_W-1:0] brake_ticks;
        logic [TIMER_W-1:0] settle_ticks;
        logic [TIMER_W-1:0] init_reverse_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        pulses_per_unit:    4'd2,
        return_edges:       4'd1,
        filter_samples:     6'd46,
        brake_ticks:        8'd20,
        settle_ticks:       8'd10,
        init_reverse_ticks: 8'd50
    };

    typedef struct packed {
        logic             func;
        logic             lane;
        logic [LEN_W-1:0] length;
        logic             gate_zero;
        logic             gate_one;
    } t_in_item;

    typedef struct packed {
        logic [1:0] motor_zero;
        logic [1:0] motor_one;
        logic       led_zero;
        logic       led_one;
        logic       solenoid_zero;
        logic       solenoid_one;
        logic       busy_zero;
        logic       busy_one;
        logic       done_zero;
        logic       done_one;
        logic       rejected;
    } t_out_item;

    // Status of one lane after the current request, handed to the top level.
    typedef struct packed {
        t_motor motor;
        logic   led;
        logic   solenoid;
        logic   busy;
        logic   done;
        logic   rejected;
    } t_lane_stat;

endpackage

[hdl/tfls_in_if.sv]
// Request channel interface carrying ticks and feed commands.
`timescale 1ns / 1ps

interface tfls_in_if;
    logic               valid;
    logic               ready;
    tfls_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/tfls_out_if.sv]
// Result channel interface carrying the lane status after each request.
`timescale 1ns / 1ps

interface tfls_out_if;
    logic                valid;
    logic                ready;
    tfls_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/tfls_lane.sv]
// Per-lane gate filter, edge counter and motor phase sequencer.
`timescale 1ns / 1ps

module tfls_lane #(
    parameter int EDGE_COUNTER_WIDTH = tfls_pkg::EDGE_CNT_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic                          i_cmd,
    input  logic [tfls_pkg::LEN_W-1:0]    i_length,
    input  logic                          i_gate,
    input  tfls_pkg::t_cfg                i_cfg,
    output tfls_pkg::t_lane_stat          o_stat
);
    import tfls_pkg::*;

    localparam int EC_W  = EDGE_COUNTER_WIDTH;
    localparam int CMP_W = (EC_W > TGT_W) ? EC_W : TGT_W;
    localparam logic [EC_W-1:0] EC_MAX = {EC_W{1'b1}};

    t_phase              r_phase,  n_phase;
    logic [EC_W-1:0]     r_ec,     n_ec;
    logic [TIMER_W-1:0]  r_timer,  n_timer;
    logic                r_qual,   n_qual;
    logic [FILT_W-1:0]   r_sc,     n_sc;
    logic [TGT_W-1:0]    r_target, n_target;
    logic                r_sol,    n_sol;

    logic [FILT_W-1:0]   sc_inc;
    logic [TIMER_W-1:0]  t_inc;
    logic                feeding;
    logic                done;
    logic                rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_INIT;
            r_ec    <= '0;
            r_timer <= '0;
            r_qual  <= 1'b0;
            r_sc    <= '0;
            r_sol   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ec    <= n_ec;
            r_timer <= n_timer;
            r_qual  <= n_qual;
            r_sc    <= n_sc;
            r_sol   <= n_sol;
        end
    end

    // The target is only read while feeding, which a command always precedes.
    always_ff @(posedge i_clk) begin
        r_target <= n_target;
    end

    always_comb begin
        n_phase  = r_phase;
        n_ec     = r_ec;
        n_timer  = r_timer;
        n_qual   = r_qual;
        n_sc     = r_sc;
        n_target = r_target;
        n_sol    = r_sol;
        done     = 1'b0;
        rej      = 1'b0;
        feeding  = (r_phase == PH_FWD) || (r_phase == PH_REV) ||
                   (r_phase == PH_BRAKE) || (r_phase == PH_SETTLE);
        sc_inc   = (r_sc == {FILT_W{1'b1}}) ? r_sc : r_sc + FILT_W'(1);
        t_inc    = (r_timer == {TIMER_W{1'b1}}) ? r_timer : r_timer + TIMER_W'(1);

        if (i_tick) begin
            // The gate filter runs first, so an edge qualified now is seen below.
            if (i_gate == r_qual) begin
                n_sc = '0;
            end else if (sc_inc >= i_cfg.filter_samples) begin
                n_qual = i_gate;
                n_sc   = '0;
                if (feeding && (r_ec != EC_MAX)) begin
                    n_ec = r_ec + EC_W'(1);
                end
            end else begin
                n_sc = sc_inc;
            end

            case (r_phase)
                PH_INIT: begin
                    if (t_inc >= i_cfg.init_reverse_ticks) begin
                        n_phase = PH_IDLE;
                        n_timer = '0;
                    end else begin
                        n_timer = t_inc;
                    end
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_FWD: begin
                    if (CMP_W'(n_ec) > CMP_W'(r_target)) begin
                        n_ec    = '0;
                        n_phase = PH_REV;
                    end
                end
                PH_REV: begin
                    if (n_ec > EC_W'(i_cfg.return_edges)) begin
                        n_phase = PH_BRAKE;
                        n_timer = '0;
                    end
                end
                PH_BRAKE: begin
                    if (t_inc >= i_cfg.brake_ticks) begin
                        n_phase = PH_SETTLE;
                        n_timer = '0;
                    end else begin
                        n_timer = t_inc;
                    end
                end
                PH_SETTLE: begin
                    if (t_inc >= i_cfg.settle_ticks) begin
                        n_phase = PH_IDLE;
                        n_timer = '0;
                        done    = 1'b1;
                    end else begin
                        n_timer = t_inc;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (i_cmd) begin
            if (r_phase != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                n_ec     = '0;
                n_target = TGT_W'(i_cfg.pulses_per_unit) * TGT_W'(i_length);
                n_sol    = 1'b1;
                n_phase  = PH_FWD;
                n_timer  = '0;
            end
        end
    end

    always_comb begin
        o_stat.led      = (n_phase == PH_FWD) || (n_phase == PH_REV) ||
                          (n_phase == PH_BRAKE) || (n_phase == PH_SETTLE);
        o_stat.solenoid = n_sol;
        o_stat.busy     = (n_phase != PH_IDLE);
        o_stat.done     = done;
        o_stat.rejected = rej;
        case (n_phase)
            PH_INIT:  o_stat.motor = MOTOR_REVERSE;
            PH_FWD:   o_stat.motor = MOTOR_FORWARD;
            PH_REV:   o_stat.motor = MOTOR_REVERSE;
            PH_BRAKE: o_stat.motor = MOTOR_BRAKE;
            default:  o_stat.motor = MOTOR_COAST;
        endcase
    end

`ifndef SYNTHESIS
    // The reverse count always starts from zero when the forward run ends.
    a_rev_starts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_REV && $past(r_phase) == PH_FWD) |-> (r_ec == '0))
        else $error("edge count not cleared on entry to reverse");

    // A feed can only start from an idle lane.
    a_fwd_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FWD && $past(r_phase) != PH_FWD) |-> ($past(r_phase) == PH_IDLE))
        else $error("forward entered from a busy phase");

    // Once closed, the solenoid stays closed until reset.
    a_sol_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sol |=> r_sol)
        else $error("solenoid reopened without reset");
`endif

endmodule

[hdl/tape_feeder_lane_sequencer_top.sv]
// Top level of the two-lane tape feeder motor sequencer.
`timescale 1ns / 1ps

// Each request is either a 1 ms tick, carrying the sampled encoder gate level of
// both lanes, or a feed command for one lane; every request yields exactly one
// result holding motor drive, LED, solenoid, busy and done for both lanes plus a
// rejected flag for a command sent to a busy lane. A request is taken on every
// clock cycle in which the result register is empty or being emptied, so the
// sustained rate is one request per cycle while the result side keeps up, and
// its result is in the result register on the following cycle, as the lane
// outputs are combinational and feed straight into that output register. After
// reset each lane reverses for init_reverse_ticks ticks before going idle.
// Gate changes count as edges only once they have held for filter_samples
// ticks, and only while a lane is feeding; the edge counter saturates, so a
// feed whose target reaches the counter maximum never finishes. Configuration
// is written through the plain write port and should only change while no
// request is outstanding; the feed target is fixed when the command is taken,
// the other settings are used live.
module tape_feeder_lane_sequencer_top #(
    parameter int EDGE_COUNTER_WIDTH = tfls_pkg::EDGE_CNT_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tfls_in_if.sink                           i_in,
    tfls_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [tfls_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tfls_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import tfls_pkg::*;

    t_cfg       r_cfg;
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_out_item  n_out_data;

    logic       in_ready;
    logic       accept;
    logic       tick;
    logic [1:0] cmd;
    t_lane_stat stat0;
    t_lane_stat stat1;

    // The result register frees up in the same cycle it is read out. Nothing is
    // taken while reset is held, as the lanes would drop the request.
    assign in_ready   = i_rst_n && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && in_ready;
    assign tick       = accept && (i_in.data.func == FUNC_TICK);
    assign cmd[0]     = accept && (i_in.data.func == FUNC_FEED) && !i_in.data.lane;
    assign cmd[1]     = accept && (i_in.data.func == FUNC_FEED) && i_in.data.lane;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Configuration registers; writes to unknown indices are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PULSES_PER_UNIT:    r_cfg.pulses_per_unit    <= i_cfg_wdata[PPU_W-1:0];
                CFG_RETURN_EDGES:       r_cfg.return_edges       <= i_cfg_wdata[3:0];
                CFG_FILTER_SAMPLES:     r_cfg.filter_samples     <= i_cfg_wdata[FILT_W-1:0];
                CFG_BRAKE_TICKS:        r_cfg.brake_ticks        <= i_cfg_wdata;
                CFG_SETTLE_TICKS:       r_cfg.settle_ticks       <= i_cfg_wdata;
                CFG_INIT_REVERSE_TICKS: r_cfg.init_reverse_ticks <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tfls_lane #(
        .EDGE_COUNTER_WIDTH (EDGE_COUNTER_WIDTH)
    ) u_lane0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_cmd    (cmd[0]),
        .i_length (i_in.data.length),
        .i_gate   (i_in.data.gate_zero),
        .i_cfg    (r_cfg),
        .o_stat   (stat0)
    );

    tfls_lane #(
        .EDGE_COUNTER_WIDTH (EDGE_COUNTER_WIDTH)
    ) u_lane1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_cmd    (cmd[1]),
        .i_length (i_in.data.length),
        .i_gate   (i_in.data.gate_one),
        .i_cfg    (r_cfg),
        .o_stat   (stat1)
    );

    always_comb begin
        n_out_data.motor_zero    = stat0.motor;
        n_out_data.motor_one     = stat1.motor;
        n_out_data.led_zero      = stat0.led;
        n_out_data.led_one       = stat1.led;
        n_out_data.solenoid_zero = stat0.solenoid;
        n_out_data.solenoid_one  = stat1.solenoid;
        n_out_data.busy_zero     = stat0.busy;
        n_out_data.busy_one      = stat1.busy;
        n_out_data.done_zero     = stat0.done;
        n_out_data.done_one      = stat1.done;
        n_out_data.rejected      = stat0.rejected || stat1.rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    // Every accepted request leaves a result waiting on the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no result");

    // A rejection can only come from a feed command, never from a tick.
    a_reject_on_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.data.func == FUNC_TICK) |=> !r_out_data.rejected)
        else $error("tick reported as rejected");

    // A lane reporting done has returned to idle in the same result.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.done_zero || r_out_data.done_one)) |->
        ((!r_out_data.done_zero || !r_out_data.busy_zero) &&
         (!r_out_data.done_one || !r_out_data.busy_one)))
        else $error("done reported on a busy lane");
`endif

endmodule

[sim/tape_feeder_lane_sequencer_top_tb.sv]
// Self-checking testbench for the two-lane tape feeder sequencer, with its own lane predictor.
`timescale 1ns / 1ps

// Every request is either a 1 ms tick or a feed command, and each one yields exactly one
// status result. The bench keeps its own copy of both lane sequences and of the live
// settings. It works out the expected status at the moment a request is taken, queues it,
// and compares each status that leaves the block, field by field, with the oldest entry.
// Directed tests come first: the reverse after reset, zero-length timers, the gate
// debounce, and long brake and settle times. The randomised traffic comes between them
// and the saturating edge counter test, which runs last because a saturated lane never
// goes idle again. Settings are only written once no result is outstanding.
module tape_feeder_lane_sequencer_top_tb;
    import tfls_pkg::*;

    localparam int                EDGE_W      = EDGE_CNT_W_DEF;
    localparam logic [EDGE_W-1:0] EDGE_FULL   = '1;
    localparam int                HALF_PERIOD = 5;
    localparam int                CYCLE_LIMIT = 400000;
    localparam int                MAX_PRINTED = 40;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    tfls_in_if  req_if ();
    tfls_out_if stat_if ();

    tape_feeder_lane_sequencer_top #(
        .EDGE_COUNTER_WIDTH (EDGE_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if),
        .o_out       (stat_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Predicted state of both lanes, plus the settings as the block currently holds them.
    t_cfg               live_cfg;
    t_phase             lane_phase    [2];
    logic [EDGE_W-1:0]  lane_edges    [2];
    logic [TIMER_W-1:0] lane_timer    [2];
    logic               lane_level    [2];
    logic [FILT_W-1:0]  lane_stable   [2];
    logic [TGT_W-1:0]   lane_target   [2];
    logic               lane_solenoid [2];

    // Statuses still owed by the block, oldest first.
    t_out_item expected_status [$];

    // Percentage of cycles in which the request side holds back, and the result side stalls.
    int req_gap_pct;
    int stall_pct;

    int mismatches;
    int results_seen;
    int cycle_count;

    // Encoder levels that the tick requests present, and how long each lane keeps its level.
    logic gate_drive [2];
    int   gate_hold  [2];

    // ------------------------------------------------------------------------------------
    // Lane predictor
    // ------------------------------------------------------------------------------------

    function automatic void reset_lanes();
        live_cfg = CFG_RESET;
        for (int k = 0; k < 2; k++) begin
            lane_phase[k]    = PH_INIT;
            lane_edges[k]    = '0;
            lane_timer[k]    = '0;
            lane_level[k]    = 1'b0;
            lane_stable[k]   = '0;
            lane_target[k]   = '0;
            lane_solenoid[k] = 1'b0;
        end
    endfunction

    // The LED is lit, and edges are counted, from the command until the settle time ends.
    function automatic logic lane_feeding(int k);
        return lane_phase[k] inside {PH_FWD, PH_REV, PH_BRAKE, PH_SETTLE};
    endfunction

    function automatic t_motor motor_for(t_phase ph);
        case (ph)
            PH_INIT:  return MOTOR_REVERSE;
            PH_FWD:   return MOTOR_FORWARD;
            PH_REV:   return MOTOR_REVERSE;
            PH_BRAKE: return MOTOR_BRAKE;
            default:  return MOTOR_COAST;
        endcase
    endfunction

    // The phase timer saturates rather than wrapping.
    function automatic logic [TIMER_W-1:0] bump_lane_timer(int k);
        if (lane_timer[k] != '1) lane_timer[k] = lane_timer[k] + 1'b1;
        return lane_timer[k];
    endfunction

    // A new gate level is qualified once it has differed on filter_samples ticks in a row.
    // A filter setting of zero therefore behaves as one.
    function automatic void debounce_gate(int k, logic gate);
        if (gate == lane_level[k]) begin
            lane_stable[k] = '0;
        end else begin
            if (lane_stable[k] != '1) lane_stable[k] = lane_stable[k] + 1'b1;
            if (lane_stable[k] >= live_cfg.filter_samples) begin
                lane_level[k]  = gate;
                lane_stable[k] = '0;
                if (lane_feeding(k) && lane_edges[k] != EDGE_FULL) begin
                    lane_edges[k] = lane_edges[k] + 1'b1;
                end
            end
        end
    endfunction

    // One tick on one lane: debounce first, then the phase check. Returns high when the
    // feed completes on this tick.
    function automatic logic advance_lane(int k, logic gate);
        logic finished;
        finished = 1'b0;
        debounce_gate(k, gate);
        case (lane_phase[k])
            PH_INIT: begin
                if (bump_lane_timer(k) >= live_cfg.init_reverse_ticks) begin
                    lane_phase[k] = PH_IDLE;
                    lane_timer[k] = '0;
                end
            end
            PH_FWD: begin
                if (lane_edges[k] > lane_target[k]) begin
                    lane_edges[k] = '0;
                    lane_phase[k] = PH_REV;
                end
            end
            PH_REV: begin
                if (lane_edges[k] > live_cfg.return_edges) begin
                    lane_phase[k] = PH_BRAKE;
                    lane_timer[k] = '0;
                end
            end
            PH_BRAKE: begin
                if (bump_lane_timer(k) >= live_cfg.brake_ticks) begin
                    lane_phase[k] = PH_SETTLE;
                    lane_timer[k] = '0;
                end
            end
            PH_SETTLE: begin
                if (bump_lane_timer(k) >= live_cfg.settle_ticks) begin
                    lane_phase[k] = PH_IDLE;
                    lane_timer[k] = '0;
                    finished      = 1'b1;
                end
            end
            default: begin
                lane_phase[k] = PH_IDLE;
            end
        endcase
        return finished;
    endfunction

    // Applies one request to the predicted lanes and returns the status it should produce.
    function automatic t_out_item predict_status(t_in_item req);
        t_out_item st;
        logic      fin [2];
        int        k;
        st     = '0;
        fin[0] = 1'b0;
        fin[1] = 1'b0;
        if (req.func == FUNC_TICK) begin
            fin[0] = advance_lane(0, req.gate_zero);
            fin[1] = advance_lane(1, req.gate_one);
        end else begin
            k = int'(req.lane);
            if (lane_phase[k] != PH_IDLE) begin
                st.rejected = 1'b1;
            end else begin
                lane_edges[k]    = '0;
                lane_target[k]   = TGT_W'(live_cfg.pulses_per_unit) * TGT_W'(req.length);
                lane_solenoid[k] = 1'b1;
                lane_phase[k]    = PH_FWD;
                lane_timer[k]    = '0;
            end
        end
        st.motor_zero    = motor_for(lane_phase[0]);
        st.motor_one     = motor_for(lane_phase[1]);
        st.led_zero      = lane_feeding(0);
        st.led_one       = lane_feeding(1);
        st.solenoid_zero = lane_solenoid[0];
        st.solenoid_one  = lane_solenoid[1];
        st.busy_zero     = (lane_phase[0] != PH_IDLE);
        st.busy_one      = (lane_phase[1] != PH_IDLE);
        st.done_zero     = fin[0];
        st.done_one      = fin[1];
        return st;
    endfunction

    // ------------------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------------------

    task automatic report_mismatch(string detail);
        if (mismatches < MAX_PRINTED) $display("ERROR %s", detail);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [1:0] got, logic [1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    // Outputs are sampled at the rising edge, before the block updates them. The queue is
    // only popped here, so each status meets the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && stat_if.valid && stat_if.ready) begin
            got = stat_if.data;
            if (expected_status.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                          results_seen));
            end else begin
                want = expected_status.pop_front();
                check_field("motor_zero",    got.motor_zero,        want.motor_zero);
                check_field("motor_one",     got.motor_one,         want.motor_one);
                check_field("led_zero",      2'(got.led_zero),      2'(want.led_zero));
                check_field("led_one",       2'(got.led_one),       2'(want.led_one));
                check_field("solenoid_zero", 2'(got.solenoid_zero), 2'(want.solenoid_zero));
                check_field("solenoid_one",  2'(got.solenoid_one),  2'(want.solenoid_one));
                check_field("busy_zero",     2'(got.busy_zero),     2'(want.busy_zero));
                check_field("busy_one",      2'(got.busy_one),      2'(want.busy_one));
                check_field("done_zero",     2'(got.done_zero),     2'(want.done_zero));
                check_field("done_one",      2'(got.done_one),      2'(want.done_one));
                check_field("rejected",      2'(got.rejected),      2'(want.rejected));
            end
            results_seen++;
        end
    end

    // The result side stalls at random; its ready changes only on the falling edge.
    always @(negedge i_clk) begin
        stat_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL tape_feeder_lane_sequencer_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------------------------

    // Presents one request and returns at the edge that takes it. Valid is left high, so
    // back-to-back requests need no second assignment in the same time step.
    task automatic send_request(t_in_item req);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < req_gap_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= req;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_status.push_back(predict_status(req));
    endtask

    // Lowers valid; called before anything other than a further request is done.
    task automatic pause_requests();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
    endtask

    // The lane and length fields of a tick carry no meaning, so they are randomised.
    task automatic send_tick(logic g0, logic g1);
        t_in_item req;
        req.func      = FUNC_TICK;
        req.lane      = 1'($urandom_range(0, 1));
        req.length    = LEN_W'($urandom_range(0, 255));
        req.gate_zero = g0;
        req.gate_one  = g1;
        send_request(req);
    endtask

    // Gate fields of a command are ignored by the block, so they are randomised too.
    task automatic send_feed(logic lane, logic [LEN_W-1:0] len);
        t_in_item req;
        req.func      = FUNC_FEED;
        req.lane      = lane;
        req.length    = len;
        req.gate_zero = 1'($urandom_range(0, 1));
        req.gate_one  = 1'($urandom_range(0, 1));
        send_request(req);
    endtask

    // A setting is written only when no status is owed, and after a pause before the write edge.
    task automatic write_setting(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        pause_requests();
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PULSES_PER_UNIT:    live_cfg.pulses_per_unit    = value[PPU_W-1:0];
            CFG_RETURN_EDGES:       live_cfg.return_edges       = value[3:0];
            CFG_FILTER_SAMPLES:     live_cfg.filter_samples     = value[FILT_W-1:0];
            CFG_BRAKE_TICKS:        live_cfg.brake_ticks        = value;
            CFG_SETTLE_TICKS:       live_cfg.settle_ticks       = value;
            CFG_INIT_REVERSE_TICKS: live_cfg.init_reverse_ticks = value;
            default: ;
        endcase
    endtask

    // Ticks with both gates flipping every 'hold' ticks until both lanes are idle, or
    // until max_ticks have gone by for a lane that is meant to stay busy.
    task automatic run_ticks_until_idle(int hold, int max_ticks);
        int n;
        n = 0;
        while (n < max_ticks && (lane_phase[0] != PH_IDLE || lane_phase[1] != PH_IDLE)) begin
            if (n % hold == 0) begin
                gate_drive[0] = ~gate_drive[0];
                gate_drive[1] = ~gate_drive[1];
            end
            send_tick(gate_drive[0], gate_drive[1]);
            n++;
        end
    endtask

    // Pulses, filter, brake and settle settings are mostly kept small so that feeds finish
    // often. Upper bits of narrow registers are left random, as the block must ignore them.
    task automatic randomise_setting();
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] value;
        idx   = t_cfg_idx'($urandom_range(CFG_PULSES_PER_UNIT, CFG_INIT_REVERSE_TICKS));
        value = CFG_DATA_W'($urandom);
        case (idx)
            CFG_PULSES_PER_UNIT: value[3:0] = 4'($urandom_range(0, 4));
            CFG_FILTER_SAMPLES:  value[5:0] = 6'($urandom_range(0, 4));
            CFG_BRAKE_TICKS, CFG_SETTLE_TICKS: begin
                if ($urandom_range(0, 9) != 0) value = CFG_DATA_W'($urandom_range(0, 6));
            end
            default: ;
        endcase
        write_setting(idx, value);
    endtask

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Both lanes reverse after reset and refuse commands. Lane 0's gate is held high for
    // long enough to qualify under the reset filter, which must not count as an edge. The
    // reverse time is read live, so raising it holds the lanes back and zero frees them.
    task automatic test_init_reverse();
        send_feed(1'b0, 8'd5);
        send_feed(1'b1, 8'd255);
        repeat (46) send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b1, 1'b1);
        write_setting(CFG_INIT_REVERSE_TICKS, 8'd255);
        repeat (3) send_tick(1'b1, 1'b1);
        write_setting(CFG_INIT_REVERSE_TICKS, 8'd0);
        send_tick(1'b1, 1'b1);
    endtask

    // The shortest sequences: zero brake and settle still last one tick each. A second
    // command to a busy lane is rejected. A pulses setting of zero makes any length a
    // single-edge feed, which also carries the widest length values.
    task automatic test_zero_time_feed();
        write_setting(CFG_PULSES_PER_UNIT, 8'd1);
        write_setting(CFG_RETURN_EDGES, 8'd0);
        write_setting(CFG_FILTER_SAMPLES, 8'd1);
        write_setting(CFG_BRAKE_TICKS, 8'd0);
        write_setting(CFG_SETTLE_TICKS, 8'd0);
        // Gate activity while idle counts nothing.
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_feed(1'b0, 8'd0);
        send_feed(1'b0, 8'd3);
        send_feed(1'b1, 8'd1);
        run_ticks_until_idle(1, 40);
        write_setting(CFG_PULSES_PER_UNIT, 8'd0);
        send_feed(1'b0, 8'd255);
        send_feed(1'b1, 8'd128);
        run_ticks_until_idle(1, 40);
    endtask

    // Debounce: a filter setting of zero acts as one; pulses shorter than the filter never
    // count, so the lane keeps driving forward; the longest filter still finishes.
    task automatic test_gate_filter();
        write_setting(CFG_PULSES_PER_UNIT, 8'd1);
        write_setting(CFG_FILTER_SAMPLES, 8'd0);
        send_feed(1'b0, 8'd1);
        run_ticks_until_idle(1, 40);
        write_setting(CFG_FILTER_SAMPLES, 8'd3);
        send_feed(1'b1, 8'd2);
        run_ticks_until_idle(2, 12);
        run_ticks_until_idle(3, 200);
        write_setting(CFG_FILTER_SAMPLES, 8'd63);
        send_feed(1'b0, 8'd0);
        run_ticks_until_idle(63, 400);
    endtask

    // The largest counts and times on one lane, with a short feed alongside on the other.
    task automatic test_long_timers();
        write_setting(CFG_FILTER_SAMPLES, 8'd1);
        write_setting(CFG_PULSES_PER_UNIT, 8'd15);
        write_setting(CFG_RETURN_EDGES, 8'd15);
        write_setting(CFG_BRAKE_TICKS, 8'd255);
        write_setting(CFG_SETTLE_TICKS, 8'd255);
        send_feed(1'b0, 8'd2);
        send_feed(1'b1, 8'd0);
        run_ticks_until_idle(1, 800);
    endtask

    // Mostly well-formed traffic: commands to idle lanes and gate runs that just outlast
    // the filter, with glitches, random gate noise and commands to busy lanes mixed in.
    task automatic test_random_traffic(int n_items);
        logic             lane;
        logic [LEN_W-1:0] len;
        int               span;
        int               cmd_pct;
        write_setting(CFG_FILTER_SAMPLES, 8'd1);
        write_setting(CFG_PULSES_PER_UNIT, 8'd2);
        write_setting(CFG_BRAKE_TICKS, 8'd2);
        write_setting(CFG_SETTLE_TICKS, 8'd1);
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 99) begin
                randomise_setting();
                randomise_setting();
            end
            cmd_pct = (lane_phase[0] == PH_IDLE || lane_phase[1] == PH_IDLE) ? 30 : 4;
            if ($urandom_range(0, 99) < cmd_pct) begin
                if (lane_phase[0] == PH_IDLE && lane_phase[1] != PH_IDLE) begin
                    lane = 1'b0;
                end else if (lane_phase[1] == PH_IDLE && lane_phase[0] != PH_IDLE) begin
                    lane = 1'b1;
                end else begin
                    lane = 1'($urandom_range(0, 1));
                end
                if ($urandom_range(0, 4) == 0) lane = 1'($urandom_range(0, 1));
                len = ($urandom_range(0, 49) == 0) ? LEN_W'($urandom_range(8, 31))
                                                   : LEN_W'($urandom_range(0, 7));
                send_feed(lane, len);
            end else if ($urandom_range(0, 9) == 0) begin
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                span = (live_cfg.filter_samples == 0) ? 1 : live_cfg.filter_samples;
                for (int k = 0; k < 2; k++) begin
                    if (gate_hold[k] <= 0) begin
                        gate_drive[k] = ~gate_drive[k];
                        gate_hold[k]  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span)
                                                                    : span + $urandom_range(0, 1);
                    end
                    gate_hold[k]--;
                end
                send_tick(gate_drive[0], gate_drive[1]);
            end
        end
    endtask

    // The edge counter saturates: a target one below full still finishes, while a target
    // beyond it keeps lane 1 driving forward for the rest of the run.
    task automatic test_edge_saturation();
        write_setting(CFG_FILTER_SAMPLES, 8'd1);
        write_setting(CFG_RETURN_EDGES, 8'd0);
        write_setting(CFG_BRAKE_TICKS, 8'd0);
        write_setting(CFG_SETTLE_TICKS, 8'd0);
        write_setting(CFG_PULSES_PER_UNIT, 8'd14);
        send_feed(1'b0, 8'd73);
        run_ticks_until_idle(1, 1200);
        write_setting(CFG_PULSES_PER_UNIT, 8'd8);
        send_feed(1'b1, 8'd128);
        write_setting(CFG_PULSES_PER_UNIT, 8'd1);
        send_feed(1'b0, 8'd2);
        run_ticks_until_idle(1, 1100);
        send_feed(1'b1, 8'd1);
    endtask

    // ------------------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------------------

    initial begin
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        stat_if.ready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_PULSES_PER_UNIT;
        i_cfg_wdata   = '0;
        mismatches    = 0;
        results_seen  = 0;
        cycle_count   = 0;
        gate_drive[0] = 1'b0;
        gate_drive[1] = 1'b0;
        gate_hold[0]  = 0;
        gate_hold[1]  = 0;
        reset_lanes();

        // Requests rarely held back, results stalled most of the time.
        req_gap_pct = 7;
        stall_pct   = 79;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_init_reverse();
        test_zero_time_feed();
        test_gate_filter();

        // The other way round: requests held back often, results seldom stalled.
        req_gap_pct = 79;
        stall_pct   = 7;
        test_long_timers();
        test_random_traffic(400);

        // No idling on either side.
        req_gap_pct = 0;
        stall_pct   = 0;
        test_random_traffic(400);
        test_edge_saturation();

        // Drain: every request has a status, so an empty queue means the block is done.
        pause_requests();
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS tape_feeder_lane_sequencer_top");
        end else begin
            $display("FAIL tape_feeder_lane_sequencer_top");
        end
        $finish;
    end

endmodule
